/* hw/rtl/firsat_pkg.sv */
// ----------------------------------------------------------------------------
// firsat_pkg: shared definitions for the saturating FIR filter
// Widths, filter length, command encoding and back-end states.
// ----------------------------------------------------------------------------
package firsat_pkg;

    // Filter length; the tap address and tap count widths follow from it.
    localparam int TAPS      = 64;
    localparam int TAP_AW    = $clog2(TAPS);
    localparam int CNT_W     = $clog2(TAPS + 1);

    localparam int SAMPLE_W  = 12;
    localparam int TAP_IDX_W = 6;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 14;

    // Tap index widened so that it can be compared against TAPS.
    localparam int IDX_EXT_W = (CNT_W > TAP_IDX_W) ? CNT_W : TAP_IDX_W;

    // Signed coefficient times zero-extended sample, and the running sum.
    localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W     = PROD_W + CNT_W;

    localparam int Q_SHIFT   = 15;
    localparam int OUT_MAX   = 4096;
    localparam int OUT_MIN   = -4096;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Request type codes on the input channel.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TAP    = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_TAP_WR,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic [SAMPLE_W-1:0]        sample;
        logic [TAP_AW-1:0]          tap_addr;
        logic signed [COEF_W-1:0]   coef;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_back_state;

endpackage

/* hw/rtl/firsat_front.sv */
// ----------------------------------------------------------------------------
// firsat_front: request intake and command queue
// Accepts requests, turns them into back-end commands and holds them in a
// short queue so that intake and the multiply-accumulate run independently.
// ----------------------------------------------------------------------------
module firsat_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic [firsat_pkg::SAMPLE_W-1:0]       i_sample_value,
    input  logic [firsat_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic signed [firsat_pkg::COEF_W-1:0]  i_tap_value,
    output firsat_pkg::t_cmd_head                 o_head,
    input  logic                                  i_pop
);

    firsat_pkg::t_cmd                      w_cmd;
    logic [firsat_pkg::IDX_EXT_W-1:0]      w_idx_ext;
    logic                                  w_idx_ok;
    logic                                  w_push;

    firsat_pkg::t_cmd                      r_queue [firsat_pkg::QUEUE_DEPTH];
    logic [firsat_pkg::Q_AW-1:0]           r_wr_ptr;
    logic [firsat_pkg::Q_AW-1:0]           r_rd_ptr;
    logic [firsat_pkg::Q_CNT_W-1:0]        r_count;
    logic [firsat_pkg::Q_AW-1:0]           n_wr_ptr;
    logic [firsat_pkg::Q_AW-1:0]           n_rd_ptr;
    logic [firsat_pkg::Q_CNT_W-1:0]        n_count;

    // A tap write outside the filter length becomes a no-op command.
    assign w_idx_ext = firsat_pkg::IDX_EXT_W'(i_tap_index);
    assign w_idx_ok  = (w_idx_ext < firsat_pkg::IDX_EXT_W'(firsat_pkg::TAPS));

    always_comb begin
        w_cmd.sample   = i_sample_value;
        w_cmd.tap_addr = w_idx_ext[firsat_pkg::TAP_AW-1:0];
        w_cmd.coef     = i_tap_value;
        case (i_req_type)
            firsat_pkg::REQ_SAMPLE: begin
                w_cmd.kind = firsat_pkg::CMD_SAMPLE;
            end
            firsat_pkg::REQ_TAP: begin
                w_cmd.kind = w_idx_ok ? firsat_pkg::CMD_TAP_WR : firsat_pkg::CMD_NOP;
            end
            default: begin
                w_cmd.kind = firsat_pkg::CMD_NOP;
            end
        endcase
    end

    assign o_in_ready = (r_count != firsat_pkg::Q_CNT_W'(firsat_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == firsat_pkg::Q_AW'(firsat_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == firsat_pkg::Q_AW'(firsat_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* hw/rtl/firsat_back.sv */
// ----------------------------------------------------------------------------
// firsat_back: coefficient and history storage with a shared MAC
// Executes queued commands; a sample runs one multiply-accumulate per tap,
// then scales, clamps and hands the result to the output register.
// ----------------------------------------------------------------------------
module firsat_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  firsat_pkg::t_cmd_head                 i_head,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [firsat_pkg::OUT_W-1:0]   o_filtered_value
);

    localparam logic signed [firsat_pkg::ACC_W-1:0] L_MAX =
        firsat_pkg::ACC_W'(firsat_pkg::OUT_MAX);
    localparam logic signed [firsat_pkg::ACC_W-1:0] L_MIN =
        firsat_pkg::ACC_W'(firsat_pkg::OUT_MIN);
    localparam logic signed [firsat_pkg::ACC_W-1:0] L_BIAS =
        firsat_pkg::ACC_W'((1 << firsat_pkg::Q_SHIFT) - 1);

    firsat_pkg::t_back_state                   r_state;
    firsat_pkg::t_back_state                   n_state;

    logic signed [firsat_pkg::COEF_W-1:0]      r_tap_mem  [firsat_pkg::TAPS];
    logic [firsat_pkg::SAMPLE_W-1:0]           r_hist_mem [firsat_pkg::TAPS];
    logic [firsat_pkg::TAPS-1:0]               r_tap_vld;
    logic [firsat_pkg::TAPS-1:0]               r_hist_vld;

    logic [firsat_pkg::TAP_AW-1:0]             r_newest;
    logic [firsat_pkg::TAP_AW-1:0]             r_rptr;
    logic [firsat_pkg::CNT_W-1:0]              r_cnt;
    logic [firsat_pkg::TAP_AW-1:0]             w_new_pos;

    logic signed [firsat_pkg::COEF_W-1:0]      r_tap_q;
    logic [firsat_pkg::SAMPLE_W-1:0]           r_hist_q;
    logic                                      r_tap_ok;
    logic                                      r_hist_ok;
    logic                                      r_rd_vld;

    logic signed [firsat_pkg::COEF_W-1:0]      w_coef;
    logic signed [firsat_pkg::SAMPLE_W:0]      w_samp;
    logic signed [firsat_pkg::PROD_W-1:0]      r_prod;
    logic                                      r_mul_vld;
    logic signed [firsat_pkg::ACC_W-1:0]       r_acc;

    logic signed [firsat_pkg::ACC_W-1:0]       w_biased;
    logic signed [firsat_pkg::ACC_W-1:0]       w_quot;
    logic signed [firsat_pkg::ACC_W-1:0]       w_clamped;

    logic                                      w_out_free;
    logic                                      w_start;
    logic                                      w_tap_wr;
    logic                                      w_issue;
    logic                                      w_load;
    logic                                      w_last;
    logic                                      r_out_vld;
    logic signed [firsat_pkg::OUT_W-1:0]       r_out_val;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_last     = (r_cnt == firsat_pkg::CNT_W'(firsat_pkg::TAPS - 1));
    assign w_new_pos  = (r_newest == firsat_pkg::TAP_AW'(firsat_pkg::TAPS - 1)) ?
                        '0 : r_newest + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            firsat_pkg::ST_IDLE: begin
                if (i_head.valid && (i_head.cmd.kind == firsat_pkg::CMD_SAMPLE)) begin
                    n_state = firsat_pkg::ST_RUN;
                end
            end
            firsat_pkg::ST_RUN: begin
                if (w_last) begin
                    n_state = firsat_pkg::ST_DRAIN;
                end
            end
            firsat_pkg::ST_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state = firsat_pkg::ST_DONE;
                end
            end
            firsat_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = firsat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = firsat_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop    = 1'b0;
        w_start  = 1'b0;
        w_tap_wr = 1'b0;
        w_issue  = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            firsat_pkg::ST_IDLE: begin
                o_pop    = i_head.valid;
                w_start  = i_head.valid && (i_head.cmd.kind == firsat_pkg::CMD_SAMPLE);
                w_tap_wr = i_head.valid && (i_head.cmd.kind == firsat_pkg::CMD_TAP_WR);
            end
            firsat_pkg::ST_RUN: begin
                w_issue = 1'b1;
            end
            firsat_pkg::ST_DONE: begin
                w_load = w_out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Storage: at most one write and one registered read per memory each cycle.
    always_ff @(posedge i_clk) begin
        if (w_tap_wr) begin
            r_tap_mem[i_head.cmd.tap_addr] <= i_head.cmd.coef;
        end
        if (w_start) begin
            r_hist_mem[w_new_pos] <= i_head.cmd.sample;
        end
        r_tap_q   <= r_tap_mem[r_cnt[firsat_pkg::TAP_AW-1:0]];
        r_hist_q  <= r_hist_mem[r_rptr];
        r_tap_ok  <= r_tap_vld[r_cnt[firsat_pkg::TAP_AW-1:0]];
        r_hist_ok <= r_hist_vld[r_rptr];
    end

    // Entries never written read as zero.
    assign w_coef = r_tap_ok  ? r_tap_q : '0;
    assign w_samp = r_hist_ok ? {1'b0, r_hist_q} : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= w_coef * w_samp;
    end

    // Truncate toward zero, then clamp.
    assign w_biased  = r_acc + (r_acc[firsat_pkg::ACC_W-1] ? L_BIAS : '0);
    assign w_quot    = w_biased >>> firsat_pkg::Q_SHIFT;
    assign w_clamped = (w_quot > L_MAX) ? L_MAX : ((w_quot < L_MIN) ? L_MIN : w_quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= firsat_pkg::ST_IDLE;
            r_tap_vld  <= '0;
            r_hist_vld <= '0;
            r_newest   <= '0;
            r_rptr     <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_acc      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= w_issue;
            r_mul_vld <= r_rd_vld;
            if (w_tap_wr) begin
                r_tap_vld[i_head.cmd.tap_addr] <= 1'b1;
            end
            if (w_start) begin
                r_hist_vld[w_new_pos] <= 1'b1;
                r_newest              <= w_new_pos;
                r_rptr                <= w_new_pos;
                r_cnt                 <= '0;
            end else if (w_issue) begin
                r_rptr <= (r_rptr == '0) ?
                          firsat_pkg::TAP_AW'(firsat_pkg::TAPS - 1) : r_rptr - 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end
            if (w_start) begin
                r_acc <= '0;
            end else if (r_mul_vld) begin
                r_acc <= r_acc + firsat_pkg::ACC_W'(r_prod);
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_val <= firsat_pkg::OUT_W'(w_clamped);
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_filtered_value = r_out_val;

endmodule

/* hw/rtl/fir_filter_saturating.sv */
// ----------------------------------------------------------------------------
// fir_filter_saturating: saturating direct-form FIR filter
// Sample and coefficient requests in, clamped filter results out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries two kinds of request.
// A coefficient request (i_req_type = 1) writes one signed Q1.15 tap and
// produces no result; an index at or beyond the filter length is ignored.
// A sample request (i_req_type = 0) pushes a 12-bit unsigned sample into the
// history and produces exactly one result on the output channel
// (o_out_valid / i_out_ready): the tap-weighted sum of the newest samples,
// divided by 2^15 with truncation toward zero and clamped to +/-4096.
// A single shared multiply-accumulate unit walks the taps one per cycle, and a
// sample holds the back end until its result is loaded into the result register;
// each product passes the memory read and product registers before it is added
// into the accumulator.
// Coefficient requests drain from the queue at one per cycle while the back end is idle.
// A two-entry queue decouples intake from the MAC, and the result register
// lets the next sample be computed while a finished result is still waiting.
// If the receiver stalls, the result holds, the next result waits in the MAC,
// and once the queue fills o_in_ready drops.
// Reset clears all taps and the sample history to zero and empties the queue.
// ----------------------------------------------------------------------------
module fir_filter_saturating (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic [firsat_pkg::SAMPLE_W-1:0]       i_sample_value,
    input  logic [firsat_pkg::TAP_IDX_W-1:0]      i_tap_index,
    input  logic signed [firsat_pkg::COEF_W-1:0]  i_tap_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [firsat_pkg::OUT_W-1:0]   o_filtered_value
);

    // Head of the command queue and the back end's pop strobe.
    firsat_pkg::t_cmd_head w_head;
    logic                  w_pop;

    // Front end: classifies each request and queues it.
    firsat_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .i_tap_index    (i_tap_index),
        .i_tap_value    (i_tap_value),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    // Back end: tap and history storage, MAC, scaling and the result register.
    firsat_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_value (o_filtered_value)
    );

endmodule

/* hw/rtl/firsat_checker.sv */
// ----------------------------------------------------------------------------
// firsat_checker: port-level checks for the saturating FIR filter
// Watches the top-level channels and flags results that break the contract.
// ----------------------------------------------------------------------------
module firsat_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [firsat_pkg::OUT_W-1:0]   o_filtered_value
);

    // Samples accepted whose result has not yet been taken.
    logic [3:0] r_pending;
    logic       w_in_smp;
    logic       w_out_acc;

    assign w_in_smp  = i_in_valid && o_in_ready && (i_req_type == firsat_pkg::REQ_SAMPLE);
    assign w_out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_smp && !w_out_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (!w_in_smp && w_out_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered_value))
        else $error("result dropped or changed while stalled");

    // Results stay inside the clamp range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_filtered_value <= firsat_pkg::OUT_W'(firsat_pkg::OUT_MAX)) &&
                        (o_filtered_value >= firsat_pkg::OUT_W'(firsat_pkg::OUT_MIN)))
        else $error("result outside clamp range");

    // Every result belongs to an accepted sample; coefficient writes give none.
    a_out_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != '0))
        else $error("result without an outstanding sample");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fir_filter_saturating firsat_checker u_firsat_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_req_type       (i_req_type),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_filtered_value (o_filtered_value)
);
